// ===== hw/rtl/hrsp_pkg.sv =====
`timescale 1ns / 1ps
package hrsp_pkg;

   // phase codes
   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_METHOD  = 3'd1;
   localparam logic [2:0] PH_PATH    = 3'd2;
   localparam logic [2:0] PH_VERSION = 3'd3;
   localparam logic [2:0] PH_KEY     = 3'd4;
   localparam logic [2:0] PH_VALUE   = 3'd5;
   localparam logic [2:0] PH_BODY    = 3'd6;

   // event codes
   localparam logic [2:0] EV_QUIET    = 3'd0;
   localparam logic [2:0] EV_METHOD   = 3'd1;
   localparam logic [2:0] EV_PATH     = 3'd2;
   localparam logic [2:0] EV_VERSION  = 3'd3;
   localparam logic [2:0] EV_HEADER   = 3'd4;
   localparam logic [2:0] EV_BODY     = 3'd5;
   localparam logic [2:0] EV_COMPLETE = 3'd6;
   localparam logic [2:0] EV_REJECT   = 3'd7;

   // reject reasons
   localparam logic [2:0] RJ_NONE     = 3'd0;
   localparam logic [2:0] RJ_METHOD   = 3'd1;
   localparam logic [2:0] RJ_PATH     = 3'd2;
   localparam logic [2:0] RJ_VERSION  = 3'd3;
   localparam logic [2:0] RJ_HEADERS  = 3'd4;
   localparam logic [2:0] RJ_BODY     = 3'd5;
   localparam logic [2:0] RJ_TRUNC    = 3'd6;
   localparam logic [2:0] RJ_OVERLONG = 3'd7;

   // path automaton codes
   localparam logic [1:0] PA_START = 2'd0;
   localparam logic [1:0] PA_SLASH = 2'd1;
   localparam logic [1:0] PA_SEG   = 2'd2;
   localparam logic [1:0] PA_BAD   = 2'd3;

   localparam int DEF_MAX_BODY_BYTES    = 8191;
   localparam int DEF_MAX_OTHER_HEADERS = 99;
   localparam int DEF_MAX_KEY_BYTES     = 255;
   localparam int DEF_MAX_VALUE_BYTES   = 1023;
   localparam int DEF_MAX_PATH_BYTES    = 2047;

   // field widths
   localparam int BODY_W  = 13;
   localparam int TALLY_W = 7;

   typedef struct packed {
      logic [2:0]         event_res;
      logic [3:0]         method_code;
      logic [1:0]         version_code;
      logic [1:0]         header_kind;
      logic [TALLY_W-1:0] other_header_count;
      logic [BODY_W-1:0]  declared_length;
      logic [7:0]         body_byte;
      logic [2:0]         reject_reason;
      logic               last;
   } rsp_type;

   // method name byte at position, 0 past the end
   function automatic logic [7:0] meth_chr(input logic [3:0] m, input logic [2:0] p);
      logic [55:0] s;
      case (m)
         4'd0: s = {"GET", 32'h0};
         4'd1: s = {"POST", 24'h0};
         4'd2: s = {"PUT", 32'h0};
         4'd3: s = {"DELETE", 8'h0};
         4'd4: s = {"HEAD", 24'h0};
         4'd5: s = "OPTIONS";
         4'd6: s = {"PATCH", 16'h0};
         4'd7: s = {"TRACE", 16'h0};
         default: s = "CONNECT";
      endcase
      return s[6'(55 - 8 * int'(p)) -: 8];
   endfunction

   function automatic logic [2:0] meth_len(input logic [3:0] m);
      case (m)
         4'd0, 4'd2: return 3'd3;
         4'd1, 4'd4: return 3'd4;
         4'd3: return 3'd6;
         4'd6, 4'd7: return 3'd5;
         default: return 3'd7;
      endcase
   endfunction

   function automatic logic [7:0] ver_chr(input logic [1:0] v, input logic [2:0] p);
      logic [63:0] s;
      case (v)
         2'd0: s = "HTTP/1.0";
         2'd1: s = "HTTP/1.1";
         default: s = "HTTP/2.0";
      endcase
      return s[6'(63 - 8 * int'(p)) -: 8];
   endfunction

   function automatic logic [7:0] key_chr(input logic [1:0] k, input logic [3:0] p);
      logic [111:0] s;
      case (k)
         2'd0: s = {"host", 80'h0};
         2'd1: s = {"user-agent", 32'h0};
         default: s = "content-length";
      endcase
      return s[7'(111 - 8 * int'(p)) -: 8];
   endfunction

   function automatic logic [3:0] key_len(input logic [1:0] k);
      case (k)
         2'd0: return 4'd4;
         2'd1: return 4'd10;
         default: return 4'd14;
      endcase
   endfunction

   function automatic logic seg_char(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || (b >= "0" && b <= "9")
         || b == "." || b == "_" || b == "?" || b == "-";
   endfunction

endpackage

// ===== hw/rtl/http_request_stream_parser.sv =====
`timescale 1ns / 1ps
// HTTP request parser, one request byte per cycle while the result channel is not stalled.
// Input channel req_*: a raw byte with first (start of request) and final_req
// (end of buffer). A request is taken when req_valid is high and req_stall low.
// Result channel rsp_*: exactly one result per request byte, carrying an event
// code (method, path, version, header line, body byte, complete, rejected),
// latched method/version codes, header kind, header tally, content length,
// body byte, reject reason and a last flag on the closing result.
// Latency: the result for a byte is valid the cycle after it is taken.
// Throughput: one byte per cycle unless req_stall holds the parser; the parser
// state updates in one step from the incoming byte and its state registers,
// the result lands in one output register.
// A new byte is accepted while the output register holds a result, as long as
// that result is taken in the same cycle; when rsp_stall is high and a result
// is waiting, req_stall goes high and the parser holds.
// Reset (synchronous) empties the output register and puts the parser in its
// idle phase, where bytes are dropped until one arrives with first set.
module http_request_stream_parser #(
   parameter int MAX_BODY_BYTES    = hrsp_pkg::DEF_MAX_BODY_BYTES,
   parameter int MAX_OTHER_HEADERS = hrsp_pkg::DEF_MAX_OTHER_HEADERS,
   parameter int MAX_KEY_BYTES     = hrsp_pkg::DEF_MAX_KEY_BYTES,
   parameter int MAX_VALUE_BYTES   = hrsp_pkg::DEF_MAX_VALUE_BYTES,
   parameter int MAX_PATH_BYTES    = hrsp_pkg::DEF_MAX_PATH_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first,
   input  logic        req_final_req,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic [3:0]  rsp_method_code,
   output logic [1:0]  rsp_version_code,
   output logic [1:0]  rsp_header_kind,
   output logic [6:0]  rsp_other_header_count,
   output logic [12:0] rsp_declared_length,
   output logic [7:0]  rsp_body_byte,
   output logic [2:0]  rsp_reject_reason,
   output logic        rsp_last
);
   import hrsp_pkg::*;

   logic    step;
   rsp_type res;
   logic    valid_ff;
   rsp_type out_ff;

   assign req_stall = valid_ff && rsp_stall;
   assign step      = req_valid && !req_stall;

   hrsp_core #(
      .MAX_BODY_BYTES(MAX_BODY_BYTES),
      .MAX_OTHER_HEADERS(MAX_OTHER_HEADERS),
      .MAX_KEY_BYTES(MAX_KEY_BYTES),
      .MAX_VALUE_BYTES(MAX_VALUE_BYTES),
      .MAX_PATH_BYTES(MAX_PATH_BYTES)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .step(step),
      .data_byte(req_data_byte),
      .first(req_first),
      .final_req(req_final_req),
      .rsp(res)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= res;
      end
   end

   assign rsp_valid              = valid_ff;
   assign rsp_event_res          = out_ff.event_res;
   assign rsp_method_code        = out_ff.method_code;
   assign rsp_version_code       = out_ff.version_code;
   assign rsp_header_kind        = out_ff.header_kind;
   assign rsp_other_header_count = out_ff.other_header_count;
   assign rsp_declared_length    = out_ff.declared_length;
   assign rsp_body_byte          = out_ff.body_byte;
   assign rsp_reject_reason      = out_ff.reject_reason;
   assign rsp_last               = out_ff.last;

   // a request taken always yields a result next cycle
   a_step_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid) else $error("request produced no result");

   // reject reason only with reject event
   a_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reject_reason != RJ_NONE |-> rsp_event_res == EV_REJECT)
      else $error("reason without reject");

   // reject and complete always close the request
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EV_REJECT || rsp_event_res == EV_COMPLETE)
      |-> rsp_last) else $error("closing event without last");

endmodule

// ===== hw/rtl/hrsp_core.sv =====
`timescale 1ns / 1ps
module hrsp_core #(
   parameter int MAX_BODY_BYTES    = hrsp_pkg::DEF_MAX_BODY_BYTES,
   parameter int MAX_OTHER_HEADERS = hrsp_pkg::DEF_MAX_OTHER_HEADERS,
   parameter int MAX_KEY_BYTES     = hrsp_pkg::DEF_MAX_KEY_BYTES,
   parameter int MAX_VALUE_BYTES   = hrsp_pkg::DEF_MAX_VALUE_BYTES,
   parameter int MAX_PATH_BYTES    = hrsp_pkg::DEF_MAX_PATH_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [7:0]        data_byte,
   input  logic              first,
   input  logic              final_req,
   output hrsp_pkg::rsp_type rsp
);
   import hrsp_pkg::*;

   localparam int POS_MAX = (MAX_PATH_BYTES > MAX_VALUE_BYTES) ?
      ((MAX_PATH_BYTES > MAX_KEY_BYTES) ? MAX_PATH_BYTES : MAX_KEY_BYTES) :
      ((MAX_VALUE_BYTES > MAX_KEY_BYTES) ? MAX_VALUE_BYTES : MAX_KEY_BYTES);
   localparam int POS_W = $clog2(POS_MAX + 1);
   localparam int LEN_W = $clog2(MAX_BODY_BYTES + 2);
   localparam int REM_W = $clog2(MAX_BODY_BYTES + 1);
   localparam int TAL_W = $clog2(MAX_OTHER_HEADERS + 1);
   localparam int MUL_W = LEN_W + 4;

   logic [2:0]       phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [8:0]       mmask_ff, mmask_in;
   logic [1:0]       pa_ff, pa_in;
   logic [2:0]       vmask_ff, vmask_in;
   logic [2:0]       kmask_ff, kmask_in;
   logic             crp_ff, crp_in;
   logic [LEN_W-1:0] lval_ff, lval_in;
   logic             lpres_ff, lpres_in;
   logic [REM_W-1:0] brem_ff, brem_in;
   logic [TAL_W-1:0] tally_ff, tally_in;
   logic [3:0]       mreg_ff, mreg_in;
   logic [1:0]       vreg_ff, vreg_in;
   logic [REM_W-1:0] cl_ff, cl_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff   <= '0;
         mmask_ff <= '1;
         pa_ff    <= PA_START;
         vmask_ff <= '1;
         kmask_ff <= '1;
         crp_ff   <= 1'b0;
         lval_ff  <= '0;
         lpres_ff <= 1'b0;
         brem_ff  <= '0;
         tally_ff <= '0;
         mreg_ff  <= '0;
         vreg_ff  <= '0;
         cl_ff    <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         mmask_ff <= mmask_in;
         pa_ff    <= pa_in;
         vmask_ff <= vmask_in;
         kmask_ff <= kmask_in;
         crp_ff   <= crp_in;
         lval_ff  <= lval_in;
         lpres_ff <= lpres_in;
         brem_ff  <= brem_in;
         tally_ff <= tally_in;
         mreg_ff  <= mreg_in;
         vreg_ff  <= vreg_in;
         cl_ff    <= cl_in;
      end
   end

   // per-byte state update
   always_comb begin
      logic [2:0]       ph, ev, rsn;
      logic [POS_W-1:0] pos;
      logic [8:0]       mm;
      logic [1:0]       pa, kind;
      logic [2:0]       vm, km;
      logic             crp, lp, lst, hit;
      logic [LEN_W-1:0] lv;
      logic [REM_W-1:0] br, cl;
      logic [TAL_W-1:0] tl;
      logic [3:0]       mr;
      logic [1:0]       vr;
      logic [7:0]       lc;
      logic [MUL_W-1:0] prod;
      ph = phase_ff; pos = pos_ff; mm = mmask_ff; pa = pa_ff; vm = vmask_ff;
      km = kmask_ff; crp = crp_ff; lv = lval_ff; lp = lpres_ff; br = brem_ff;
      tl = tally_ff; mr = mreg_ff; vr = vreg_ff; cl = cl_ff;
      ev = EV_QUIET; rsn = RJ_NONE; lst = 1'b0; kind = 2'd0; hit = 1'b0;
      lc = (data_byte >= "A" && data_byte <= "Z") ? data_byte + 8'd32 : data_byte;
      prod = '0;
      if (first) begin
         pos = '0; mm = '1; pa = PA_START; vm = '1; km = '1; crp = 1'b0; lv = '0;
         lp = 1'b0; br = '0; tl = '0; mr = '0; vr = '0; cl = '0; ph = PH_METHOD;
      end
      if (ph == PH_IDLE) begin
         // dropped
      end else if (data_byte == 8'd0 && ph != PH_BODY) begin
         rsn = RJ_TRUNC;
      end else begin
         unique case (ph)
            PH_METHOD: begin
               if (data_byte == " ") begin
                  for (int j = 8; j >= 0; j--) begin
                     if (mm[j] && POS_W'(meth_len(4'(j))) == pos) begin
                        hit = 1'b1; mr = 4'(j);
                     end
                  end
                  if (hit) begin
                     ev = EV_METHOD; ph = PH_PATH; pos = '0; pa = PA_START;
                  end else rsn = RJ_METHOD;
               end else if (pos >= POS_W'(7)) begin
                  rsn = RJ_METHOD;
               end else begin
                  for (int j = 0; j < 9; j++) begin
                     if (POS_W'(meth_len(4'(j))) <= pos ||
                         meth_chr(4'(j), pos[2:0]) != data_byte) mm[j] = 1'b0;
                  end
                  pos = pos + 1'b1;
               end
            end
            PH_PATH: begin
               if (data_byte == " " || data_byte == 8'h0d) begin
                  if (pa != PA_SLASH && pa != PA_SEG) rsn = RJ_PATH;
                  else if (data_byte == 8'h0d) rsn = RJ_VERSION;
                  else begin
                     ev = EV_PATH; ph = PH_VERSION; pos = '0; vm = '1;
                  end
               end else if (pos >= POS_W'(MAX_PATH_BYTES)) begin
                  rsn = RJ_OVERLONG;
               end else begin
                  pos = pos + 1'b1;
                  case (pa)
                     PA_START: pa = (data_byte == "/") ? PA_SLASH : PA_BAD;
                     PA_SLASH: pa = seg_char(data_byte) ? PA_SEG : PA_BAD;
                     PA_SEG: pa = (data_byte == "/") ? PA_SLASH :
                                  (seg_char(data_byte) ? PA_SEG : PA_BAD);
                     default: pa = PA_BAD;
                  endcase
               end
            end
            PH_VERSION: begin
               if (crp) begin
                  if (data_byte == 8'h0a) begin
                     crp = 1'b0; ph = PH_KEY; pos = '0; km = '1;
                  end else rsn = RJ_VERSION;
               end else if (data_byte == 8'h0d) begin
                  if (pos == POS_W'(8) && vm != 3'd0) begin
                     vr = vm[0] ? 2'd0 : (vm[1] ? 2'd1 : 2'd2);
                     ev = EV_VERSION; crp = 1'b1;
                  end else rsn = RJ_VERSION;
               end else if (data_byte == " " && pos == '0) begin
                  // leading space
               end else if (pos >= POS_W'(8)) begin
                  rsn = RJ_VERSION;
               end else begin
                  for (int j = 0; j < 3; j++)
                     if (ver_chr(2'(j), pos[2:0]) != data_byte) vm[j] = 1'b0;
                  pos = pos + 1'b1;
               end
            end
            PH_KEY: begin
               if (crp) begin
                  if (data_byte == 8'h0a) begin
                     crp = 1'b0;
                     if (lp && cl != '0) begin
                        ph = PH_BODY; br = cl;
                     end else begin
                        ev = EV_COMPLETE; lst = 1'b1; ph = PH_IDLE;
                     end
                  end else rsn = RJ_HEADERS;
               end else if (data_byte == 8'h0d) begin
                  if (pos == '0) crp = 1'b1; else rsn = RJ_HEADERS;
               end else if (data_byte == 8'h0a) begin
                  rsn = RJ_HEADERS;
               end else if (data_byte == ":") begin
                  for (int j = 0; j < 3; j++)
                     if (POS_W'(key_len(2'(j))) != pos) km[j] = 1'b0;
                  ph = PH_VALUE; pos = '0; lv = '0;
               end else if (pos >= POS_W'(MAX_KEY_BYTES)) begin
                  rsn = RJ_OVERLONG;
               end else begin
                  for (int j = 0; j < 3; j++)
                     if (POS_W'(key_len(2'(j))) <= pos ||
                         key_chr(2'(j), pos[3:0]) != lc) km[j] = 1'b0;
                  pos = pos + 1'b1;
               end
            end
            PH_VALUE: begin
               if (crp) begin
                  if (data_byte == 8'h0a) begin
                     kind = km[0] ? 2'd0 : km[1] ? 2'd1 : km[2] ? 2'd2 : 2'd3;
                     if (kind == 2'd3) begin
                        if (tl >= TAL_W'(MAX_OTHER_HEADERS)) rsn = RJ_HEADERS;
                        else tl = tl + 1'b1;
                     end else if (kind == 2'd2) begin
                        if (lv > LEN_W'(MAX_BODY_BYTES)) rsn = RJ_BODY;
                        else begin
                           cl = REM_W'(lv); lp = 1'b1;
                        end
                     end
                     if (rsn == RJ_NONE) begin
                        ev = EV_HEADER; ph = PH_KEY; pos = '0; km = '1; crp = 1'b0;
                     end
                  end else rsn = RJ_HEADERS;
               end else if (data_byte == 8'h0d) begin
                  crp = 1'b1;
               end else if (pos == '0 && (data_byte == " " || data_byte == 8'h09)) begin
                  // leading whitespace
               end else if (pos >= POS_W'(MAX_VALUE_BYTES)) begin
                  rsn = RJ_OVERLONG;
               end else begin
                  pos = pos + 1'b1;
                  if (km[2]) begin
                     if (data_byte >= "0" && data_byte <= "9") begin
                        // value saturates at one past the limit, so x10 stays narrow
                        prod = {lv, 3'b000} + {3'b000, lv, 1'b0}
                             + MUL_W'(data_byte - "0");
                        lv = (prod > MUL_W'(MAX_BODY_BYTES)) ?
                             LEN_W'(MAX_BODY_BYTES + 1) : LEN_W'(prod);
                     end else rsn = RJ_HEADERS;
                  end
               end
            end
            PH_BODY: begin
               ev = EV_BODY;
               if (br != '0) br = br - 1'b1;
               if (br == '0) begin
                  lst = 1'b1; ph = PH_IDLE;
               end
            end
            default: ph = PH_IDLE;
         endcase
      end
      if (rsn != RJ_NONE) begin
         ev = EV_REJECT; lst = 1'b1; ph = PH_IDLE;
      end
      if (final_req && ph != PH_IDLE && !lst) begin
         rsn = RJ_TRUNC; ev = EV_REJECT; lst = 1'b1; ph = PH_IDLE;
      end
      phase_in = ph; pos_in = pos; mmask_in = mm; pa_in = pa; vmask_in = vm;
      kmask_in = km; crp_in = crp; lval_in = lv; lpres_in = lp; brem_in = br;
      tally_in = tl; mreg_in = mr; vreg_in = vr; cl_in = cl;
      rsp.event_res          = ev;
      rsp.method_code        = mr;
      rsp.version_code       = vr;
      rsp.header_kind        = (ev == EV_HEADER) ? kind : 2'd0;
      rsp.other_header_count = TALLY_W'(tl);
      rsp.declared_length    = BODY_W'(cl);
      rsp.body_byte          = (ev == EV_BODY) ? data_byte : 8'd0;
      rsp.reject_reason      = rsn;
      rsp.last               = lst;
   end

endmodule
